[design/vehc_pkg.sv]
// Shared types and constants for the variable edge histogram counter.
// No dependencies; every other design file imports this package.

package vehc_pkg;

    localparam int NUM_BINS_DEF   = 7;
    localparam int COUNT_BITS_DEF = 32;

    localparam int NUM_EDGES   = 8;
    localparam int EDGE_IDX_W  = 3;
    localparam int EDGE_STEP   = 65536;
    localparam int NUM_CATS    = 16;
    localparam int CAT_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int TARGET_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int BIN_W       = 3;
    localparam int OUT_CNT_W   = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED = 2'd0,
        ST_LOW     = 2'd1,
        ST_HIGH    = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [BIN_W-1:0]     bin;
        logic [CAT_W-1:0]     cat;
    } t_item;

endpackage

[design/vehc_if.sv]
// Handshake channel interfaces for events, results and register writes.
// Depends on vehc_pkg for field widths.

interface vehc_in_if;
    import vehc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  sample_value;
    logic [TARGET_W-1:0]        target_id;
    logic                       is_left;
    logic                       spin_up;

    modport source (output valid, sample_value, target_id, is_left, spin_up, input ready);
    modport sink   (input valid, sample_value, target_id, is_left, spin_up, output ready);
endinterface

interface vehc_out_if;
    import vehc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [BIN_W-1:0]       bin_index;
    logic [OUT_CNT_W-1:0]   new_count;

    modport source (output valid, status, bin_index, new_count, input ready);
    modport sink   (input valid, status, bin_index, new_count, output ready);
endinterface

interface vehc_cfg_if;
    import vehc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [VALUE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/vehc_front.sv]
// Front end: holds the bin edge registers and classifies each accepted event.
// Depends on vehc_pkg and the channel interfaces in vehc_if.

module vehc_front import vehc_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vehc_in_if.sink     i_in,
    vehc_cfg_if.sink    i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic signed [VALUE_W-1:0] r_edge [NUM_EDGES];
    logic                      w_hit;
    logic [EDGE_IDX_W-1:0]     w_k;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign o_push      = i_in.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                r_edge[k] <= VALUE_W'(k * EDGE_STEP);
            end
        end else if (i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_EDGES))) begin
            r_edge[i_cfg.index[EDGE_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    always_comb begin
        w_hit = 1'b0;
        w_k   = '0;
        for (int k = NUM_BINS; k >= 0; k--) begin
            if (i_in.sample_value <= r_edge[k]) begin
                w_hit = 1'b1;
                w_k   = EDGE_IDX_W'(k);
            end
        end
    end

    always_comb begin
        o_item.cat = {i_in.target_id, i_in.is_left, i_in.spin_up};
        o_item.bin = '0;
        if (!w_hit) begin
            o_item.status = ST_HIGH;
        end else if (w_k == '0) begin
            o_item.status = ST_LOW;
        end else begin
            o_item.status = ST_COUNTED;
            o_item.bin    = BIN_W'(w_k - EDGE_IDX_W'(1));
        end
    end

endmodule

[design/vehc_queue.sv]
// Short queue of classified events between the front end and the counter unit.
// Depends on vehc_pkg for the item type and depth.

module vehc_queue import vehc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    output logic    o_full,
    output logic    o_valid,
    output t_item   o_item,
    input  logic    i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[design/vehc_back.sv]
// Counter unit: read-modify-write of the bin counter memory with forwarding.
// Depends on vehc_pkg and the result channel interface in vehc_if.

module vehc_back import vehc_pkg::*; #(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    vehc_out_if.source  o_out
);

    localparam int DEPTH = NUM_CATS * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);

    logic [COUNT_BITS-1:0]  r_mem [DEPTH];
    logic [DEPTH-1:0]       r_cnt_vld;
    logic                   r_b_valid;
    t_item                  r_b_item;
    logic [AW-1:0]          r_b_addr;
    logic [COUNT_BITS-1:0]  r_rd_data;
    logic                   r_rd_vld;
    logic                   r_last_vld;
    logic [AW-1:0]          r_last_addr;
    logic [COUNT_BITS-1:0]  r_last_cnt;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [BIN_W-1:0]       r_out_bin;
    logic [OUT_CNT_W-1:0]   r_out_cnt;

    logic [AW-1:0]          w_addr;
    logic                   w_go;
    logic                   w_counted;
    logic [COUNT_BITS-1:0]  w_old;
    logic [COUNT_BITS-1:0]  w_new;

    assign w_addr    = AW'(i_item.cat) * AW'(NUM_BINS) + AW'(i_item.bin);
    assign w_go      = r_b_valid && (!r_out_valid || o_out.ready);
    assign o_pop     = i_valid && (!r_b_valid || w_go);
    assign w_counted = (r_b_item.status == ST_COUNTED);

    // The previous item may have written this entry at the edge where it was read.
    always_comb begin
        if (r_last_vld && (r_last_addr == r_b_addr)) begin
            w_old = r_last_cnt;
        end else if (r_rd_vld) begin
            w_old = r_rd_data;
        end else begin
            w_old = '0;
        end
        w_new = (&w_old) ? w_old : w_old + COUNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_vld  <= 1'b0;
            r_cnt_vld   <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
                r_rd_vld  <= r_cnt_vld[w_addr];
            end else if (w_go) begin
                r_b_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_go && w_counted) begin
                r_cnt_vld[r_b_addr] <= 1'b1;
                r_last_vld          <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item  <= i_item;
            r_b_addr  <= w_addr;
            r_rd_data <= r_mem[w_addr];
        end
        if (w_go) begin
            r_out_status <= r_b_item.status;
            r_out_bin    <= r_b_item.bin;
            r_out_cnt    <= w_counted ? OUT_CNT_W'(w_new) : '0;
            if (w_counted) begin
                r_mem[r_b_addr] <= w_new;
                r_last_addr     <= r_b_addr;
                r_last_cnt      <= w_new;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.bin_index = r_out_bin;
    assign o_out.new_count = r_out_cnt;

endmodule

[design/variable_edge_histogram_counter.sv]
// Event histogrammer with programmable bin edges and sixteen event categories.
// Depends on vehc_pkg, vehc_if, vehc_front, vehc_queue and vehc_back.
//
// The block takes one event per clock cycle while the output is not stalled, and
// returns one result word per event, in order. Each result word passes through
// the queue, the counter read stage and the output register. Throughput is set
// by the counter memory, which does one read and one write per cycle; a
// back-to-back hit on the same counter is forwarded from the last write. The
// counters read as zero after reset through per-entry valid bits, so no clearing
// pass is needed. Edge registers should be written only while no event is in flight.

module variable_edge_histogram_counter import vehc_pkg::*; #(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vehc_in_if.sink     i_in,
    vehc_cfg_if.sink    i_cfg,
    vehc_out_if.source  o_out
);

    logic   w_push;
    t_item  w_push_item;
    logic   w_full;
    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_pop;

    vehc_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    vehc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    vehc_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench for variable_edge_histogram_counter: directed table, then random phases.
// Expected words (predicted here or given by the directed table) are matched to DUT words in order.
// Depends on vehc_pkg and the vehc_in_if, vehc_out_if and vehc_cfg_if interfaces.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vehc_pkg::*;

    localparam int NUM_BINS     = NUM_BINS_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int LAST_EDGE    = (NUM_BINS < NUM_EDGES) ? NUM_BINS : NUM_EDGES - 1;
    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 160;
    localparam int EDGE_PROFILES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_0         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_3         = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_7         = 8'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 8'hFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_EVENT, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_status                status;
        logic [BIN_W-1:0]       bin_index;
        logic [OUT_CNT_W-1:0]   new_count;
    } t_tally;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [VALUE_W-1:0]     word;
        logic [TARGET_W-1:0]    tgt;
        logic                   left;
        logic                   spin;
        logic                   typed;
        t_tally                 tally;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 22;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_EVENT, REG_EDGE_0, 32'h0000_0000, 2'd0, 1'b0, 1'b0, 1'b1, '{ST_LOW, 3'd0, 32'd0}},
        '{ROW_EVENT, REG_EDGE_0, 32'h8000_0000, 2'd3, 1'b1, 1'b1, 1'b1, '{ST_LOW, 3'd0, 32'd0}},
        '{ROW_EVENT, REG_EDGE_0, 32'h7FFF_FFFF, 2'd1, 1'b0, 1'b1, 1'b1, '{ST_HIGH, 3'd0, 32'd0}},
        '{ROW_EVENT, REG_EDGE_0, 32'h0007_0001, 2'd2, 1'b1, 1'b0, 1'b1, '{ST_HIGH, 3'd0, 32'd0}},
        '{ROW_EVENT, REG_EDGE_0, 32'h0000_0001, 2'd0, 1'b0, 1'b0, 1'b1,
          '{ST_COUNTED, 3'd0, 32'd1}},
        '{ROW_EVENT, REG_EDGE_0, 32'h0001_0000, 2'd0, 1'b0, 1'b0, 1'b1,
          '{ST_COUNTED, 3'd0, 32'd2}},
        '{ROW_EVENT, REG_EDGE_0, 32'h0007_0000, 2'd3, 1'b1, 1'b1, 1'b1,
          '{ST_COUNTED, 3'd6, 32'd1}},
        '{ROW_EVENT, REG_EDGE_0, 32'h0001_8000, 2'd2, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h0001_8000, 2'd2, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h0004_0000, 2'd1, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_EDGE_0, 32'h8000_0000, 2'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_EDGE_7, 32'h7FFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h8000_0000, 2'd2, 1'b1, 1'b0, 1'b1, '{ST_LOW, 3'd0, 32'd0}},
        '{ROW_EVENT, REG_EDGE_0, 32'h8000_0001, 2'd2, 1'b1, 1'b0, 1'b1,
          '{ST_COUNTED, 3'd0, 32'd1}},
        '{ROW_EVENT, REG_EDGE_0, 32'h7FFF_FFFF, 2'd3, 1'b0, 1'b0, 1'b1,
          '{ST_COUNTED, 3'd6, 32'd1}},
        '{ROW_WRITE, REG_UNMAPPED_FIRST, 32'h7FFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_LAST, 32'h0000_0000, 2'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h7FFF_FFFF, 2'd3, 1'b0, 1'b0, 1'b1,
          '{ST_COUNTED, 3'd6, 32'd2}},
        '{ROW_WRITE, REG_EDGE_3, 32'hFF9C_0000, 2'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h0000_0005, 2'd1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'h0002_4000, 2'd1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_EVENT, REG_EDGE_0, 32'hFF00_0000, 2'd0, 1'b1, 1'b1, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    vehc_in_if  in_if ();
    vehc_out_if out_if ();
    vehc_cfg_if cfg_if ();

    variable_edge_histogram_counter #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    logic signed [VALUE_W-1:0]  bin_edges [NUM_EDGES];
    logic [COUNT_BITS-1:0]      hist_counts [NUM_CATS*NUM_BINS];
    t_tally                     pending_tallies [$];
    t_idle_mode                 idle_mode = IDLE_NONE;
    int                         mismatches = 0;
    int                         cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 78;
            IDLE_BOTH:   return 25;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 78;
            IDLE_BOTH:     return 25;
            default:       return 0;
        endcase
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void queue_tally(t_tally entry);
        pending_tallies.insert(pending_tallies.size(), entry);
    endfunction

    function automatic t_tally bin_event(logic signed [VALUE_W-1:0] sample,
                                         logic [TARGET_W-1:0] tgt, logic left, logic spin);
        t_tally res;
        int     hit;
        int     slot;
        hit = -1;
        for (int k = 0; k <= LAST_EDGE; k++) begin
            if (hit < 0 && sample <= bin_edges[k]) begin
                hit = k;
            end
        end
        res.status    = ST_HIGH;
        res.bin_index = '0;
        res.new_count = '0;
        if (hit == 0) begin
            res.status = ST_LOW;
        end else if (hit > 0) begin
            slot = int'({tgt, left, spin}) * NUM_BINS + hit - 1;
            if (hist_counts[slot] != '1) begin
                hist_counts[slot] = hist_counts[slot] + 1'b1;
            end
            res.status    = ST_COUNTED;
            res.bin_index = BIN_W'(hit - 1);
            res.new_count = OUT_CNT_W'(hist_counts[slot]);
        end
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_sample();
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(9);
        k = $urandom_range(NUM_EDGES - 1);
        if (sel < 5) begin
            return bin_edges[k] + VALUE_W'($urandom_range(4)) - 32'd2;
        end else if (sel < 8) begin
            return bin_edges[k] + VALUE_W'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
        end
        return $urandom;
    endfunction

    task automatic send_event(input logic [VALUE_W-1:0] value, input logic [TARGET_W-1:0] tgt,
                              input logic left, input logic spin,
                              input logic typed, input t_tally given);
        t_tally predicted;
        cfg_if.valid <= 1'b0;
        while ($urandom_range(99) < sender_idle_pct()) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_value <= value;
        in_if.target_id    <= tgt;
        in_if.is_left      <= left;
        in_if.spin_up      <= spin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = bin_event(value, tgt, left, spin);
        queue_tally(typed ? given : predicted);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx < NUM_EDGES) begin
            bin_edges[idx[EDGE_IDX_W-1:0]] = data;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_tallies.size() != 0);
    endtask

    task automatic program_edges(input int profile);
        logic [VALUE_W-1:0] new_edges [NUM_EDGES];
        logic [VALUE_W-1:0] acc;
        acc = VALUE_W'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
        for (int k = 0; k < NUM_EDGES; k++) begin
            case (profile)
                0: new_edges[k] = VALUE_W'(k * EDGE_STEP);
                1: begin
                    new_edges[k] = acc;
                    acc = acc + VALUE_W'($urandom_range(32'h0002_0000, 1));
                end
                2: new_edges[k] = 32'h8000_0000 + VALUE_W'(k) * 32'h2492_4924;
                default: new_edges[k] = $urandom;
            endcase
        end
        if (profile == 2) begin
            new_edges[NUM_EDGES-1] = 32'h7FFF_FFFF;
        end else if (profile == 4) begin
            new_edges[0] = 32'h7FFF_FFFF;
        end
        for (int k = 0; k < NUM_EDGES; k++) begin
            cfg_write(REG_EDGE_0 + CFG_IDX_W'(k), new_edges[k]);
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_tallies.size() == 0) begin
                note_failure($sformatf("unexpected word status=%0d bin=%0d count=%0d",
                    out_if.status, out_if.bin_index, out_if.new_count));
            end else begin
                want = pending_tallies.pop_front();
                if (out_if.status !== want.status || out_if.bin_index !== want.bin_index ||
                        out_if.new_count !== want.new_count) begin
                    note_failure($sformatf(
                        "expected status=%0d bin=%0d count=%0d, got status=%0d bin=%0d count=%0d",
                        want.status, want.bin_index, want.new_count,
                        out_if.status, out_if.bin_index, out_if.new_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.target_id    = '0;
        in_if.is_left      = 1'b0;
        in_if.spin_up      = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        for (int k = 0; k < NUM_EDGES; k++) begin
            bin_edges[k] = VALUE_W'(k * EDGE_STEP);
        end
        for (int k = 0; k < NUM_CATS * NUM_BINS; k++) begin
            hist_counts[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                if (r == 0 || directed_rows[r-1].kind == ROW_EVENT) begin
                    drain_results();
                end
                cfg_write(directed_rows[r].reg_idx, directed_rows[r].word);
            end else begin
                send_event(directed_rows[r].word, directed_rows[r].tgt, directed_rows[r].left,
                           directed_rows[r].spin, directed_rows[r].typed,
                           directed_rows[r].tally);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            program_edges(phase % EDGE_PROFILES);
            idle_mode = t_idle_mode'(phase % 4);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                send_event(pick_sample(), TARGET_W'($urandom), 1'($urandom), 1'($urandom),
                           1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
